### hw/rtl/tempo_to_timer_settings_core_macros.svh
// ----------------------------------------------------------------------------
// Tempo to timer settings: assertion macros
// Shorthand for clocked checks on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef TEMPO_TO_TIMER_SETTINGS_CORE_MACROS_SVH
`define TEMPO_TO_TIMER_SETTINGS_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TTTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ttts_pkg.sv
// ----------------------------------------------------------------------------
// Tempo to timer settings: package
// Widths, register indexes, status codes and the prescaler shift table.
// ----------------------------------------------------------------------------
package ttts_pkg;

	localparam int CMP_W   = 16;
	localparam int DIV_W   = 32;
	localparam int TEMPO_W = 16;
	localparam int TICKS_W = 8;
	localparam int OUT_W   = 16;
	localparam int CNT_W   = $clog2(DIV_W);

	localparam logic [DIV_W-1:0] CMP_LIMIT = DIV_W'((64'd1 << CMP_W) - 64'd1);

	localparam logic [DIV_W-1:0]   CYCLES_RESET = 32'd1440000000;
	localparam logic [TICKS_W-1:0] TICKS_RESET  = 8'd24;

	localparam logic REG_CYCLES = 1'b0;
	localparam logic REG_TICKS  = 1'b1;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_TEMPO_ZERO = 2'd1;
	localparam logic [1:0] STATUS_NO_FIT     = 2'd2;

	localparam logic [2:0] SEL_NONE  = 3'd0;
	localparam logic [2:0] SEL_FIRST = 3'd1;
	localparam logic [2:0] SEL_LAST  = 3'd7;

	typedef logic [3:0] shift_t;

	function automatic shift_t prescale_shift(input logic [2:0] sel);
		shift_t s;
		case (sel)
			3'd1:    s = 4'd0;
			3'd2:    s = 4'd1;
			3'd3:    s = 4'd2;
			3'd4:    s = 4'd3;
			3'd5:    s = 4'd6;
			3'd6:    s = 4'd8;
			3'd7:    s = 4'd10;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/tempo_to_timer_settings_core.sv
// ----------------------------------------------------------------------------
// Tempo to timer settings core
// Divides cycles per minute by tempo, picks the prescaler and divides the
// beat compare by ticks per beat, all on one shared restoring divider.
// ----------------------------------------------------------------------------
// Order: tempo zero is answered straight from idle; otherwise the cycles divide,
// the prescaler scan (k = 1..7) and the tick divide, and no fit ends at the scan.
// A request is taken only in idle, not while busy; the 32 plus 16 divider steps,
// one bit a cycle, and the scan set its run. A request may start as done pulses.
// Reset: async active low; clears control and results, restores register defaults.
module tempo_to_timer_settings_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [ttts_pkg::DIV_W-1:0]   cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [ttts_pkg::TEMPO_W-1:0] tempo_bpm,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [2:0]                   prescale_select,
	output logic [ttts_pkg::OUT_W-1:0]   beat_compare,
	output logic [ttts_pkg::OUT_W-1:0]   tick_compare
);

`include "tempo_to_timer_settings_core_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_TICK = 2'd3;

	localparam logic [ttts_pkg::CNT_W-1:0] DIV_LAST  = ttts_pkg::CNT_W'(ttts_pkg::DIV_W - 1);
	localparam logic [ttts_pkg::CNT_W-1:0] TICK_LAST = ttts_pkg::CNT_W'(ttts_pkg::CMP_W - 1);

	logic [ttts_pkg::DIV_W-1:0]   cycles_q;
	logic [ttts_pkg::TICKS_W-1:0] ticks_q;

	logic [1:0]                   state_q;
	logic [ttts_pkg::CNT_W-1:0]   cnt_q;
	logic [2:0]                   sel_q;
	logic [ttts_pkg::DIV_W-1:0]   dvd_q;
	logic [ttts_pkg::TEMPO_W-1:0] rem_q;
	logic [ttts_pkg::TEMPO_W-1:0] dsr_q;
	logic [ttts_pkg::CMP_W-1:0]   cmp_q;

	logic                         done_q;
	logic [1:0]                   status_q;
	logic [2:0]                   psel_q;
	logic [ttts_pkg::OUT_W-1:0]   beat_q;
	logic [ttts_pkg::OUT_W-1:0]   tick_q;

	logic                         accept;
	logic [ttts_pkg::TEMPO_W:0]   trial;
	logic [ttts_pkg::TEMPO_W:0]   diff;
	logic                         ge;
	logic [ttts_pkg::TEMPO_W-1:0] rem_d;
	logic [ttts_pkg::DIV_W-1:0]   dvd_d;
	logic [ttts_pkg::DIV_W-1:0]   shifted;
	logic                         fits;
	logic [ttts_pkg::TEMPO_W-1:0] tick_dsr;

	logic                         zero_req;
	logic                         run_req;
	logic                         zero_flag;
	logic                         err_res;
	logic                         ok_res;
	logic                         res_zero;
	logic                         res_sane;

	assign accept = start && (state_q == ST_IDLE);

	// one restoring step
	assign trial = {rem_q, dvd_q[ttts_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = !diff[ttts_pkg::TEMPO_W];
	assign rem_d = ge ? diff[ttts_pkg::TEMPO_W-1:0] : trial[ttts_pkg::TEMPO_W-1:0];
	assign dvd_d = {dvd_q[ttts_pkg::DIV_W-2:0], ge};

	assign shifted  = dvd_q >> ttts_pkg::prescale_shift(sel_q);
	assign fits     = (shifted <= ttts_pkg::CMP_LIMIT);
	assign tick_dsr = (ticks_q == '0) ? ttts_pkg::TEMPO_W'(1) : ttts_pkg::TEMPO_W'(ticks_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_q <= ttts_pkg::CYCLES_RESET;
			ticks_q  <= ttts_pkg::TICKS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ttts_pkg::REG_CYCLES: cycles_q <= cfg_data;
				ttts_pkg::REG_TICKS:  ticks_q  <= cfg_data[ttts_pkg::TICKS_W-1:0];
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			sel_q    <= ttts_pkg::SEL_NONE;
			dvd_q    <= '0;
			rem_q    <= '0;
			dsr_q    <= '0;
			cmp_q    <= '0;
			status_q <= ttts_pkg::STATUS_OK;
			psel_q   <= ttts_pkg::SEL_NONE;
			beat_q   <= '0;
			tick_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (tempo_bpm == '0) begin
							done_q   <= 1'b1;
							status_q <= ttts_pkg::STATUS_TEMPO_ZERO;
							psel_q   <= ttts_pkg::SEL_NONE;
							beat_q   <= '0;
							tick_q   <= '0;
						end else begin
							dvd_q   <= cycles_q;
							rem_q   <= '0;
							dsr_q   <= tempo_bpm;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					dvd_q <= dvd_d;
					rem_q <= rem_d;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						sel_q   <= ttts_pkg::SEL_FIRST;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (fits) begin
						cmp_q   <= shifted[ttts_pkg::CMP_W-1:0];
						dvd_q   <= ttts_pkg::DIV_W'(shifted[ttts_pkg::CMP_W-1:0])
							<< (ttts_pkg::DIV_W - ttts_pkg::CMP_W);
						rem_q   <= '0;
						dsr_q   <= tick_dsr;
						cnt_q   <= '0;
						state_q <= ST_TICK;
					end else if (sel_q == ttts_pkg::SEL_LAST) begin
						done_q   <= 1'b1;
						status_q <= ttts_pkg::STATUS_NO_FIT;
						psel_q   <= ttts_pkg::SEL_NONE;
						beat_q   <= '0;
						tick_q   <= '0;
						state_q  <= ST_IDLE;
					end else begin
						sel_q <= sel_q + 1'b1;
					end
				end
				ST_TICK: begin
					dvd_q <= dvd_d;
					rem_q <= rem_d;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == TICK_LAST) begin
						done_q   <= 1'b1;
						status_q <= ttts_pkg::STATUS_OK;
						psel_q   <= sel_q;
						beat_q   <= ttts_pkg::OUT_W'(cmp_q);
						tick_q   <= ttts_pkg::OUT_W'(dvd_d[ttts_pkg::CMP_W-1:0]);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign prescale_select = psel_q;
	assign beat_compare    = beat_q;
	assign tick_compare    = tick_q;

	assign zero_req  = accept && (tempo_bpm == '0);
	assign run_req   = accept && (tempo_bpm != '0);
	assign zero_flag = done && (status == ttts_pkg::STATUS_TEMPO_ZERO);
	assign err_res   = done && (status != ttts_pkg::STATUS_OK);
	assign ok_res    = done && (status == ttts_pkg::STATUS_OK);
	assign res_zero  = (prescale_select == ttts_pkg::SEL_NONE) && (beat_compare == '0)
		&& (tick_compare == '0);
	assign res_sane  = (prescale_select != ttts_pkg::SEL_NONE) && (tick_compare <= beat_compare);

	`TTTS_ASSERT_NEXT(a_zero_tempo, zero_req, zero_flag, "tempo zero request not flagged")
	`TTTS_ASSERT_NEXT(a_run_busy, run_req, busy && !done, "request did not start the divider")
	`TTTS_ASSERT_SAME(a_err_zero, err_res, res_zero, "error result carries non-zero fields")
	`TTTS_ASSERT_SAME(a_ok_sel, ok_res, res_sane, "ok result with bad prescaler or tick")

endmodule
